FILE: src/swam_pkg.sv
package swam_pkg;

    // Fixed field width of a symbol beat
    localparam int SYM_W = 7;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_PATTERN = 64;
    localparam int DEF_ALPHABET    = 128;

    // Number of distinct raw symbol codes
    localparam int SYM_CODES = 1 << SYM_W;

    // Decoupling queue between front and back end
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Command carried by each input beat
    typedef enum logic [0:0] {
        CMD_PATTERN = 1'b0,
        CMD_TEXT    = 1'b1
    } t_cmd;

    // Classified beat as it travels through the queue; sym is already
    // reduced into the alphabet, which always fits the raw symbol width
    typedef struct packed {
        t_cmd             cmd;
        logic [SYM_W-1:0] sym;
        logic             start_req;
    } t_item;

    // Back-end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PAT_WR,
        BK_TXT_OLD,
        BK_TXT_UPD,
        BK_TXT_NEW
    } t_bk_state;

endpackage

FILE: src/swam_if.sv
// Input channel: one pattern or text symbol per beat
interface swam_in_if import swam_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [SYM_W-1:0] symbol;
    logic             start_req;

    modport source (output valid, output cmd, output symbol, output start_req, input ready);
    modport sink   (input valid, input cmd, input symbol, input start_req, output ready);
endinterface

// Result channel: one beat per text symbol
interface swam_out_if import swam_pkg::*; ();
    logic valid;
    logic ready;
    logic match_here;
    logic found;
    logic pattern_overflow;

    modport source (output valid, output match_here, output found, output pattern_overflow,
                    input ready);
    modport sink   (input valid, input match_here, input found, input pattern_overflow,
                    output ready);
endinterface

FILE: src/swam_ram.sv
// Simple dual-port RAM: one write port, one registered read port
module swam_ram import swam_pkg::*; #(
    parameter int WIDTH = SYM_W,
    parameter int DEPTH = DEF_ALPHABET,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read; read data holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/swam_queue.sv
// Short FIFO between the front and back end
module swam_queue import swam_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count,  n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + Q_PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + Q_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: src/swam_front.sv
// Front end: takes input beats, reduces the symbol into the alphabet
// and classifies the beat for the queue
module swam_front import swam_pkg::*; #(
    parameter int ALPHABET = DEF_ALPHABET
) (
    swam_in_if.sink i_item,
    input  logic    i_q_full,
    output logic    o_push,
    output t_item   o_item
);

    logic [SYM_W-1:0] mod_tab [SYM_CODES];

    // Constant reduction table, symbol modulo alphabet size
    for (genvar g = 0; g < SYM_CODES; g++) begin : g_mod
        assign mod_tab[g] = SYM_W'(g % ALPHABET);
    end

    assign i_item.ready = !i_q_full;
    assign o_push       = i_item.valid && !i_q_full;

    assign o_item.cmd       = t_cmd'(i_item.cmd);
    assign o_item.sym       = mod_tab[i_item.symbol];
    assign o_item.start_req = i_item.start_req;

endmodule

FILE: src/swam_back.sv
// Back end: histogram RAMs, window ring and a running mismatch count.
// The mismatch count is the number of symbols whose window count differs
// from the pattern count; a full window matches when it is zero.
module swam_back import swam_pkg::*; #(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int ALPHABET    = DEF_ALPHABET
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_item i_q_item,
    output logic o_q_pop,
    swam_out_if.source o_result
);

    localparam int AW = $clog2(ALPHABET);
    localparam int RW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int MW = $clog2(ALPHABET + 1);

    t_bk_state r_state, n_state;
    t_item     r_item, n_item;
    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_seen, n_seen;
    logic [RW-1:0] r_pos, n_pos;
    logic [MW-1:0] r_mis, n_mis;
    logic [MW-1:0] r_dist, n_dist;
    logic          r_found, n_found;
    logic          r_ovf, n_ovf;
    logic [ALPHABET-1:0] r_pvalid, n_pvalid;
    logic [ALPHABET-1:0] r_wvalid, n_wvalid;
    logic          r_prd_v, n_prd_v;
    logic          r_wrd_v, n_wrd_v;
    logic [AW-1:0] r_old, n_old;
    logic          r_out_valid, n_out_valid;
    logic          r_out_match, n_out_match;
    logic          r_out_found, n_out_found;
    logic          r_out_ovf, n_out_ovf;

    // RAM ports
    logic          p_we, p_re, w_we, w_re, ring_we, ring_re;
    logic [AW-1:0] p_waddr, p_raddr, w_waddr, w_raddr;
    logic [CW-1:0] p_wdata, p_rdata, w_wdata, w_rdata;
    logic [RW-1:0] ring_waddr, ring_raddr;
    logic [AW-1:0] ring_wdata, ring_rdata;

    // Derived values
    logic [AW-1:0] head_sym, cur_sym;
    logic [CW-1:0] p_cnt, w_cnt;
    logic [CW-1:0] e_len;
    logic          out_free;
    logic          pos_wrap;
    logic [RW-1:0] pos_next;
    logic [CW-1:0] seen_inc;
    logic [MW-1:0] mis_add, mis_rem;

    swam_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_pat_hist (
        .i_clk  (i_clk),
        .i_we   (p_we),
        .i_waddr(p_waddr),
        .i_wdata(p_wdata),
        .i_re   (p_re),
        .i_raddr(p_raddr),
        .o_rdata(p_rdata)
    );

    swam_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_win_hist (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    swam_ram #(.WIDTH(AW), .DEPTH(MAX_PATTERN)) u_win_ring (
        .i_clk  (i_clk),
        .i_we   (ring_we),
        .i_waddr(ring_waddr),
        .i_wdata(ring_wdata),
        .i_re   (ring_re),
        .i_raddr(ring_raddr),
        .o_rdata(ring_rdata)
    );

    assign head_sym = AW'(i_q_item.sym);
    assign cur_sym  = AW'(r_item.sym);

    // Entries never written since the last clear read as zero
    assign p_cnt = r_prd_v ? p_rdata : '0;
    assign w_cnt = r_wrd_v ? w_rdata : '0;

    assign e_len    = i_q_item.start_req ? '0 : r_len;
    assign out_free = !r_out_valid || o_result.ready;

    // Ring write position wraps at the pattern length
    assign pos_wrap = (CW'(r_pos) + CW'(1)) >= r_len;
    assign pos_next = pos_wrap ? '0 : r_pos + RW'(1);
    assign seen_inc = (r_seen == r_len) ? r_seen : r_seen + CW'(1);

    // Mismatch count after adding or removing one symbol
    always_comb begin
        mis_add = r_mis;
        if (w_cnt == p_cnt) begin
            mis_add = r_mis + MW'(1);
        end else if (w_cnt + CW'(1) == p_cnt) begin
            mis_add = r_mis - MW'(1);
        end
        mis_rem = r_mis;
        if (w_cnt == p_cnt) begin
            mis_rem = r_mis + MW'(1);
        end else if (w_cnt - CW'(1) == p_cnt) begin
            mis_rem = r_mis - MW'(1);
        end
    end

    // Sequencer: next state, RAM controls and result
    always_comb begin
        logic match_w;
        match_w     = 1'b0;
        n_state     = r_state;
        n_item      = r_item;
        n_len       = r_len;
        n_seen      = r_seen;
        n_pos       = r_pos;
        n_mis       = r_mis;
        n_dist      = r_dist;
        n_found     = r_found;
        n_ovf       = r_ovf;
        n_pvalid    = r_pvalid;
        n_wvalid    = r_wvalid;
        n_prd_v     = r_prd_v;
        n_wrd_v     = r_wrd_v;
        n_old       = r_old;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_match = r_out_match;
        n_out_found = r_out_found;
        n_out_ovf   = r_out_ovf;
        o_q_pop     = 1'b0;
        p_we        = 1'b0;
        p_waddr     = cur_sym;
        p_wdata     = p_cnt + CW'(1);
        p_re        = 1'b0;
        p_raddr     = cur_sym;
        w_we        = 1'b0;
        w_waddr     = cur_sym;
        w_wdata     = w_cnt + CW'(1);
        w_re        = 1'b0;
        w_raddr     = cur_sym;
        ring_we     = 1'b0;
        ring_waddr  = r_pos;
        ring_wdata  = cur_sym;
        ring_re     = 1'b0;
        ring_raddr  = r_pos;

        case (r_state)
            BK_IDLE: begin
                if (i_q_valid && !(i_q_item.cmd == CMD_TEXT && e_len == '0 && !out_free)) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    // Start mark clears every store and flag
                    if (i_q_item.start_req) begin
                        n_len    = '0;
                        n_seen   = '0;
                        n_pos    = '0;
                        n_mis    = '0;
                        n_dist   = '0;
                        n_found  = 1'b0;
                        n_ovf    = 1'b0;
                        n_pvalid = '0;
                        n_wvalid = '0;
                    end
                    if (i_q_item.cmd == CMD_PATTERN) begin
                        if (e_len < CW'(MAX_PATTERN)) begin
                            p_re    = 1'b1;
                            p_raddr = head_sym;
                            n_prd_v = !i_q_item.start_req && r_pvalid[head_sym];
                            n_state = BK_PAT_WR;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (e_len == '0) begin
                        // Empty pattern matches every text symbol
                        n_out_valid = 1'b1;
                        n_out_match = 1'b1;
                        n_out_found = 1'b1;
                        n_out_ovf   = i_q_item.start_req ? 1'b0 : r_ovf;
                        n_found     = 1'b1;
                    end else if (r_seen == r_len) begin
                        // Full window: fetch the leaving symbol first
                        ring_re    = 1'b1;
                        ring_raddr = r_pos;
                        n_state    = BK_TXT_OLD;
                    end else begin
                        // Window still filling: only the arriving symbol
                        w_re       = 1'b1;
                        w_raddr    = head_sym;
                        p_re       = 1'b1;
                        p_raddr    = head_sym;
                        n_wrd_v    = r_wvalid[head_sym];
                        n_prd_v    = r_pvalid[head_sym];
                        ring_we    = 1'b1;
                        ring_waddr = r_pos;
                        ring_wdata = head_sym;
                        n_state    = BK_TXT_NEW;
                    end
                end
            end

            BK_PAT_WR: begin
                // Count the pattern symbol; window restarts empty
                p_we             = 1'b1;
                p_waddr          = cur_sym;
                p_wdata          = p_cnt + CW'(1);
                n_pvalid[cur_sym] = 1'b1;
                n_len            = r_len + CW'(1);
                n_dist           = (p_cnt == '0) ? r_dist + MW'(1) : r_dist;
                n_mis            = (p_cnt == '0) ? r_dist + MW'(1) : r_dist;
                n_wvalid         = '0;
                n_seen           = '0;
                n_pos            = '0;
                n_state          = BK_IDLE;
            end

            BK_TXT_OLD: begin
                if (ring_rdata == cur_sym) begin
                    // Same symbol leaves and arrives: histograms unchanged
                    if (out_free) begin
                        ring_we     = 1'b1;
                        ring_waddr  = r_pos;
                        ring_wdata  = cur_sym;
                        n_pos       = pos_next;
                        match_w     = (r_mis == '0);
                        n_found     = r_found || match_w;
                        n_out_valid = 1'b1;
                        n_out_match = match_w;
                        n_out_found = r_found || match_w;
                        n_out_ovf   = r_ovf;
                        n_state     = BK_IDLE;
                    end
                end else begin
                    n_old      = ring_rdata;
                    w_re       = 1'b1;
                    w_raddr    = ring_rdata;
                    p_re       = 1'b1;
                    p_raddr    = ring_rdata;
                    n_wrd_v    = r_wvalid[ring_rdata];
                    n_prd_v    = r_pvalid[ring_rdata];
                    ring_we    = 1'b1;
                    ring_waddr = r_pos;
                    ring_wdata = cur_sym;
                    n_state    = BK_TXT_UPD;
                end
            end

            BK_TXT_UPD: begin
                // Remove the leaving symbol, then fetch the arriving one
                if (w_cnt != '0) begin
                    w_we    = 1'b1;
                    w_waddr = r_old;
                    w_wdata = w_cnt - CW'(1);
                    n_mis   = mis_rem;
                end
                w_re    = 1'b1;
                w_raddr = cur_sym;
                p_re    = 1'b1;
                p_raddr = cur_sym;
                n_wrd_v = r_wvalid[cur_sym];
                n_prd_v = r_pvalid[cur_sym];
                n_state = BK_TXT_NEW;
            end

            BK_TXT_NEW: begin
                // Add the arriving symbol and report
                if (out_free) begin
                    w_we              = 1'b1;
                    w_waddr           = cur_sym;
                    w_wdata           = w_cnt + CW'(1);
                    n_wvalid[cur_sym] = 1'b1;
                    n_mis             = mis_add;
                    n_seen            = seen_inc;
                    n_pos             = pos_next;
                    match_w           = (seen_inc == r_len) && (mis_add == '0);
                    n_found           = r_found || match_w;
                    n_out_valid       = 1'b1;
                    n_out_match       = match_w;
                    n_out_found       = r_found || match_w;
                    n_out_ovf         = r_ovf;
                    n_state           = BK_IDLE;
                end
            end

            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_len       <= '0;
            r_seen      <= '0;
            r_pos       <= '0;
            r_mis       <= '0;
            r_dist      <= '0;
            r_found     <= 1'b0;
            r_ovf       <= 1'b0;
            r_pvalid    <= '0;
            r_wvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_seen      <= n_seen;
            r_pos       <= n_pos;
            r_mis       <= n_mis;
            r_dist      <= n_dist;
            r_found     <= n_found;
            r_ovf       <= n_ovf;
            r_pvalid    <= n_pvalid;
            r_wvalid    <= n_wvalid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_prd_v     <= n_prd_v;
        r_wrd_v     <= n_wrd_v;
        r_old       <= n_old;
        r_out_match <= n_out_match;
        r_out_found <= n_out_found;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.match_here       = r_out_match;
    assign o_result.found            = r_out_found;
    assign o_result.pattern_overflow = r_out_ovf;

endmodule

FILE: src/sliding_window_anagram_match.sv
// A text beat's result is registered from BK_IDLE for an empty pattern, from BK_TXT_NEW
// while the window fills, from BK_TXT_OLD when the leaving and arriving symbols are
// equal, and via BK_TXT_OLD, BK_TXT_UPD and BK_TXT_NEW for any other full-window beat.
// A dropped pattern beat is handled in BK_IDLE, a kept one also passes BK_PAT_WR; a new
// beat is taken only in BK_IDLE, and a result beat not yet taken can hold the back end.
// Reset is synchronous, active low; control state, flags and valid bits clear at once.
module sliding_window_anagram_match import swam_pkg::*; #(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int ALPHABET    = DEF_ALPHABET
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swam_in_if.sink     i_item,
    swam_out_if.source  o_result
);

    logic  q_full;
    logic  q_push;
    logic  q_valid;
    logic  q_pop;
    t_item q_in;
    t_item q_head;

    swam_front #(.ALPHABET(ALPHABET)) u_front (
        .i_item  (i_item),
        .i_q_full(q_full),
        .o_push  (q_push),
        .o_item  (q_in)
    );

    swam_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_item (q_in),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_item (q_head),
        .i_pop  (q_pop)
    );

    swam_back #(.MAX_PATTERN(MAX_PATTERN), .ALPHABET(ALPHABET)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_item (q_head),
        .o_q_pop  (q_pop),
        .o_result (o_result)
    );

endmodule

FILE: src/swam_checker.sv
// Port-level checks on the matcher
module swam_port_checks import swam_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_cmd,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_match_here,
    input logic i_out_found,
    input logic i_out_pattern_overflow
);

    logic [7:0] r_pending;
    logic [7:0] n_pending;
    logic       in_text;
    logic       out_beat;

    // Text beats accepted whose result beat has not gone out yet
    assign in_text  = i_in_valid && i_in_ready && (i_in_cmd == CMD_TEXT);
    assign out_beat = i_out_valid && i_out_ready;

    always_comb begin
        n_pending = r_pending;
        if (in_text && !out_beat) begin
            n_pending = r_pending + 8'd1;
        end else if (out_beat && !in_text) begin
            n_pending = r_pending - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // No result beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_match_here)
            && $stable(i_out_found) && $stable(i_out_pattern_overflow))
        else $error("stalled result beat changed");

    // Every result beat belongs to an accepted text beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 8'd0)
        else $error("result beat without a pending text beat");

    // A match always raises the sticky found flag
    a_match_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_match_here |-> i_out_found)
        else $error("match reported without found");

endmodule

bind sliding_window_anagram_match swam_port_checks u_swam_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_in_valid            (i_item.valid),
    .i_in_ready            (i_item.ready),
    .i_in_cmd              (i_item.cmd),
    .i_out_valid           (o_result.valid),
    .i_out_ready           (o_result.ready),
    .i_out_match_here      (o_result.match_here),
    .i_out_found           (o_result.found),
    .i_out_pattern_overflow(o_result.pattern_overflow)
);

FILE: tb/sv/swam_checker.sv
// Watches both channels of the anagram matcher, keeps its own histogram
// model of the block and compares every result beat with the oldest
// predicted verdict.
module swam_checker import swam_pkg::*; #(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int ALPHABET    = DEF_ALPHABET
) (
    input  logic i_clk,
    input  logic i_rst_n,
    swam_in_if   i_item,
    swam_out_if  i_result,
    output int   o_errors,
    output int   o_pending,
    output int   o_results,
    output int   o_matches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic match_here;
        logic found;
        logic pattern_overflow;
    } t_verdict;

    // Model state
    int               pat_count [ALPHABET];
    int               win_count [ALPHABET];
    logic [SYM_W-1:0] win_ring  [MAX_PATTERN];
    int               pat_len;
    int               txt_seen;
    int               ring_pos;
    logic             found_q;
    logic             ovf_q;

    t_verdict verdict_q[$];
    int       err_cnt   = 0;
    int       res_cnt   = 0;
    int       match_cnt = 0;

    task automatic clear_window();
        foreach (win_count[a]) win_count[a] = 0;
        txt_seen = 0;
        ring_pos = 0;
    endtask

    task automatic clear_all();
        foreach (pat_count[a]) pat_count[a] = 0;
        clear_window();
        pat_len = 0;
        found_q = 1'b0;
        ovf_q   = 1'b0;
    endtask

    function automatic bit hist_equal();
        for (int a = 0; a < ALPHABET; a++)
            if (pat_count[a] != win_count[a]) return 1'b0;
        return 1'b1;
    endfunction

    // Apply one accepted input beat; text beats queue a verdict
    task automatic predict_beat(input logic cmd, input logic [SYM_W-1:0] raw,
                                input logic start);
        int       s;
        int       old;
        t_verdict v;
        s = int'(raw) % ALPHABET;
        if (start) clear_all();
        if (t_cmd'(cmd) == CMD_PATTERN) begin
            // pattern load; a full pattern drops the symbol
            if (pat_len < MAX_PATTERN) begin
                pat_count[s]++;
                pat_len++;
                clear_window();
            end else begin
                ovf_q = 1'b1;
            end
        end else begin
            // text scan: slide the window, oldest symbol leaves once full
            if (pat_len > 0) begin
                if (txt_seen >= pat_len) begin
                    old = int'(win_ring[ring_pos]) % ALPHABET;
                    if (win_count[old] > 0) win_count[old]--;
                end else begin
                    txt_seen++;
                end
                win_ring[ring_pos] = raw;
                win_count[s]++;
                ring_pos = (ring_pos + 1 >= pat_len) ? 0 : ring_pos + 1;
            end
            v.match_here = (txt_seen == pat_len) && hist_equal();
            if (v.match_here) found_q = 1'b1;
            v.found            = found_q;
            v.pattern_overflow = ovf_q;
            verdict_q.insert(verdict_q.size(), v);
        end
    endtask

    task automatic report_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: result %0d %s mismatch: expected %0b, actual %0b",
                     $time, res_cnt, name, want, got);
        end
    endtask

    task automatic check_result();
        t_verdict want;
        res_cnt++;
        if (i_result.match_here === 1'b1) match_cnt++;
        if (verdict_q.size() == 0) begin
            err_cnt++;
            $display("%0t: result %0d unexpected: expected none, actual match=%0b found=%0b ovf=%0b",
                     $time, res_cnt, i_result.match_here, i_result.found,
                     i_result.pattern_overflow);
        end else begin
            want = verdict_q.pop_front();
            report_field("match_here", want.match_here, i_result.match_here);
            report_field("found", want.found, i_result.found);
            report_field("pattern_overflow", want.pattern_overflow,
                         i_result.pattern_overflow);
        end
    endtask

    // Sample both channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_all();
            verdict_q.delete();
        end else begin
            if (i_item.valid === 1'b1 && i_item.ready === 1'b1)
                predict_beat(i_item.cmd, i_item.symbol, i_item.start_req);
            if (i_result.valid === 1'b1 && i_result.ready === 1'b1)
                check_result();
        end
        o_errors  <= err_cnt;
        o_pending <= verdict_q.size();
        o_results <= res_cnt;
        o_matches <= match_cnt;
    end

endmodule

FILE: tb/sv/tb_top.sv
// Stimulus and verdict for the sliding window anagram matcher
module tb_top import swam_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS = 1250;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swam_in_if  item_if ();
    swam_out_if res_if ();

    int chk_errors;
    int chk_pending;
    int chk_results;
    int chk_matches;

    sliding_window_anagram_match uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if)
    );

    swam_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_if),
        .i_result  (res_if),
        .o_errors  (chk_errors),
        .o_pending (chk_pending),
        .o_results (chk_results),
        .o_matches (chk_matches)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop for a hung handshake
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver back-pressure: a 16-bit ready pattern, re-drawn when the 7-bit tick wraps
    logic [15:0] stall_pat  = 16'hFFFF;
    logic [6:0]  stall_tick = 7'd0;

    always @(posedge i_clk) begin
        if (stall_tick == 7'd0) begin
            case ($urandom_range(0, 7))
                0, 1:    stall_pat = 16'hFFFF;
                2:       stall_pat = 16'h0001;
                3:       stall_pat = 16'h5555;
                default: stall_pat = 16'($urandom) | 16'h0100;
            endcase
        end
        res_if.ready <= stall_pat[stall_tick[3:0]];
        stall_tick   <= stall_tick + 7'd1;
    end

    int n_beats    = 0;
    int n_pattern  = 0;
    int n_text     = 0;
    int n_rounds   = 0;
    int n_overfull = 0;
    int burst_left = 0;
    bit steady     = 1'b0;
    int sym_base   = 0;
    int sym_span   = 128;

    // Symbol from the alphabet slice in use for this round
    function automatic logic [SYM_W-1:0] pick_sym();
        return SYM_W'(sym_base + $urandom_range(0, sym_span - 1));
    endfunction

    // Drive one beat and hold it until accepted; bursts end in a random gap
    task automatic send_beat(input t_cmd c, input logic [SYM_W-1:0] s, input logic st);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        item_if.valid     <= 1'b1;
        item_if.cmd       <= c;
        item_if.symbol    <= s;
        item_if.start_req <= st;
        @(posedge i_clk);
        while (item_if.ready !== 1'b1) @(posedge i_clk);
        n_beats++;
        if (c == CMD_PATTERN) n_pattern++;
        else n_text++;
    endtask

    // One round: load a pattern, then scan text built from shuffled copies
    // of it, random filler and the odd stray beat
    task automatic run_scan_round(input bit force_full);
        logic [SYM_W-1:0] pat  [64];
        logic [SYM_W-1:0] perm [64];
        logic [SYM_W-1:0] tmp;
        int plen;
        int kept;
        int nchunks;
        int cnt;
        int j;
        int r;
        n_rounds++;
        steady   = ($urandom_range(0, 4) == 0);
        sym_span = ($urandom_range(0, 3) == 0) ? 128 : $urandom_range(1, 4);
        sym_base = $urandom_range(0, 127);

        // empty pattern: every text beat matches
        if (!force_full && $urandom_range(0, 19) == 0) begin
            send_beat(CMD_TEXT, SYM_W'($urandom), 1'b1);
            repeat ($urandom_range(1, 6)) send_beat(CMD_TEXT, pick_sym(), 1'b0);
            return;
        end

        r = $urandom_range(0, 99);
        if (force_full || r >= 93) plen = 64 + $urandom_range(0, 4);
        else if (r < 60)           plen = $urandom_range(1, 6);
        else if (r < 85)           plen = $urandom_range(7, 20);
        else                       plen = $urandom_range(21, 63);
        if (plen > 64) n_overfull++;

        for (int k = 0; k < plen; k++) begin
            tmp = pick_sym();
            if (k < 64) pat[k] = tmp;
            send_beat(CMD_PATTERN, tmp, k == 0 && $urandom_range(0, 9) != 0);
        end
        kept = (plen > 64) ? 64 : plen;

        nchunks = $urandom_range(1, 4);
        for (int c = 0; c < nchunks; c++) begin
            if ($urandom_range(0, 2) != 0) begin
                // shuffled copy of the pattern
                for (int k = 0; k < kept; k++) perm[k] = pat[k];
                for (int k = kept - 1; k > 0; k--) begin
                    j       = $urandom_range(0, k);
                    tmp     = perm[k];
                    perm[k] = perm[j];
                    perm[j] = tmp;
                end
                for (int k = 0; k < kept; k++) send_beat(CMD_TEXT, perm[k], 1'b0);
            end else begin
                cnt = $urandom_range(0, kept + 2);
                for (int k = 0; k < cnt; k++) send_beat(CMD_TEXT, pick_sym(), 1'b0);
            end
            // stray beat: any command, any symbol, sometimes a restart
            if ($urandom_range(0, 9) == 0)
                send_beat(t_cmd'($urandom_range(0, 1)), SYM_W'($urandom),
                          $urandom_range(0, 3) == 0);
        end
    endtask

    int  drain_cnt;
    bit  leftover;

    initial begin
        i_rst_n           = 1'b0;
        item_if.valid     = 1'b0;
        item_if.cmd       = CMD_PATTERN;
        item_if.symbol    = '0;
        item_if.start_req = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pattern right after reset
        send_beat(CMD_TEXT, 7'h00, 1'b0);
        send_beat(CMD_TEXT, 7'h7F, 1'b0);
        // pattern {7F,00,7F} with restart; short text, then matches
        send_beat(CMD_PATTERN, 7'h7F, 1'b1);
        send_beat(CMD_PATTERN, 7'h00, 1'b0);
        send_beat(CMD_PATTERN, 7'h7F, 1'b0);
        send_beat(CMD_TEXT, 7'h00, 1'b0);
        send_beat(CMD_TEXT, 7'h7F, 1'b0);
        send_beat(CMD_TEXT, 7'h7F, 1'b0);
        send_beat(CMD_TEXT, 7'h00, 1'b0);
        send_beat(CMD_TEXT, 7'h2A, 1'b0);
        // pattern beat after text restarts the window, found stays
        send_beat(CMD_PATTERN, 7'h2A, 1'b0);
        send_beat(CMD_TEXT, 7'h7F, 1'b0);
        send_beat(CMD_TEXT, 7'h2A, 1'b0);
        send_beat(CMD_TEXT, 7'h00, 1'b0);
        send_beat(CMD_TEXT, 7'h7F, 1'b0);
        // restart on a text beat: empty pattern again
        send_beat(CMD_TEXT, 7'h55, 1'b1);
        send_beat(CMD_PATTERN, 7'h55, 1'b1);
        send_beat(CMD_TEXT, 7'h2A, 1'b0);
        send_beat(CMD_TEXT, 7'h55, 1'b0);

        // Random rounds; the first one fills the pattern to capacity, sometimes past it
        run_scan_round(1'b1);
        while (n_beats < RANDOM_BEATS + 19) run_scan_round(1'b0);
        item_if.valid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        drain_cnt = 0;
        @(posedge i_clk);
        while (chk_pending != 0 && drain_cnt < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cnt++;
        end
        leftover = (chk_pending != 0);
        if (leftover)
            $display("%0t: %0d expected results never arrived", $time, chk_pending);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats (%0d pattern, %0d text) in %0d rounds, %0d past capacity.",
                 n_beats, n_pattern, n_text, n_rounds, n_overfull);
        $display("Compared %0d results, %0d of them window matches.",
                 chk_results, chk_matches);
        if (chk_errors == 0 && !leftover) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
